// ===== sv/vsdm_pkg.sv =====
`timescale 1ns / 1ps
package vsdm_pkg;

  // Field widths
  localparam int VEL_W  = 16;  // Q4.12 velocity
  localparam int STEP_W = 15;  // unsigned slew step
  localparam int WHL_W  = 20;  // Q8.12 wheel speed
  localparam int CNT_W  = 8;   // tick counter
  localparam int GAIN_W = 18;  // unsigned Q12 gain
  localparam int FRAC_W = 12;  // fractional bits dropped by the mixer

  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic        [STEP_W-1:0] step_t;
  typedef logic signed [WHL_W-1:0] whl_t;

  typedef enum logic {
    OP_CMD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_LIN_MAX   = 3'd0,
    REG_LIN_MIN   = 3'd1,
    REG_ANG_MAX   = 3'd2,
    REG_ANG_MIN   = 3'd3,
    REG_LIN_ACCEL = 3'd4,
    REG_LIN_DECEL = 3'd5,
    REG_ANG_ACCEL = 3'd6,
    REG_ANG_DECEL = 3'd7
  } reg_idx_t;

  // Limits of one axis
  typedef struct packed {
    vel_t  vmax;
    vel_t  vmin;
    step_t accel;
    step_t decel;
  } axis_cfg_t;

  localparam vel_t  VEL_RST_MAX = 16'sd2048;
  localparam vel_t  VEL_RST_MIN = -16'sd2048;
  localparam step_t STEP_RST    = 15'd137;

endpackage

// ===== sv/velocity_smoother_drive_mixer_unit.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Transfer when       Carries
// in_      input      in_valid & ready    opcode, lin_cmd, ang_cmd
// out_     output     out_valid & ready   left/right wheel speed, timed_out
// cfg_     input      cfg_we              register index, write data
//
// Each transfer is held in the input register, then processed from it: a
// command updates the smoothed and held values and clears the tick count, a
// tick updates the count and loads the result register. One item per cycle
// while no tick waits; commands never wait on the result side. A tick waits in
// the input register while a result is still untaken. Reset (rst_n,
// synchronous) clears state and valids and loads the register defaults.
module velocity_smoother_drive_mixer_unit
  import vsdm_pkg::*;
#(
  parameter int TIMEOUT_TICKS = 3,
  parameter int LIN_GAIN_Q12  = 24824,
  parameter int ANG_GAIN_Q12  = 7447
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  vel_t        in_lin_cmd,
  input  vel_t        in_ang_cmd,

  output logic        out_valid,
  input  logic        out_ready,
  output whl_t        out_left_wheel_speed,
  output whl_t        out_right_wheel_speed,
  output logic        out_timed_out,

  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam logic [CNT_W-1:0] TO_LIM  = CNT_W'(TIMEOUT_TICKS);
  localparam logic [CNT_W-1:0] CNT_TOP = '1;

  // Configuration registers
  axis_cfg_t lin_cfg_r, ang_cfg_r;

  // Input register
  logic ivld_r;
  op_t  iop_r;
  vel_t ilin_r, iang_r;

  // Smoother state
  vel_t             last_lin_r, last_ang_r, held_lin_r, held_ang_r;
  logic [CNT_W-1:0] cnt_r;

  // Result register
  logic out_vld_r;
  whl_t left_r, right_r;
  logic to_r;

  logic             in_acc, adv, is_tick;
  vel_t             neg_ang, slew_lin, slew_ang;
  logic signed [VEL_W:0] neg_x;
  logic [CNT_W-1:0] cnt_nxt;
  logic             to_nxt;
  vel_t             mix_lin, mix_ang;
  whl_t             left_nxt, right_nxt;

  assign is_tick  = (iop_r == OP_TICK);
  // commands bypass the result register, ticks need it free
  assign adv      = ivld_r && (!is_tick || !out_vld_r || out_ready);
  assign in_ready = !ivld_r || adv;
  assign in_acc   = in_valid && in_ready;

  // negate angular part, saturating the most negative value
  always_comb begin
    neg_x = -{iang_r[VEL_W-1], iang_r};
    if (neg_x > $signed({1'b0, {(VEL_W-1){1'b1}}})) begin
      neg_ang = {1'b0, {(VEL_W-1){1'b1}}};
    end else begin
      neg_ang = neg_x[VEL_W-1:0];
    end
  end

  vsdm_slew u_slew_lin (
    .cfg (lin_cfg_r),
    .cur (last_lin_r),
    .cmd (ilin_r),
    .nxt (slew_lin)
  );

  vsdm_slew u_slew_ang (
    .cfg (ang_cfg_r),
    .cur (last_ang_r),
    .cmd (neg_ang),
    .nxt (slew_ang)
  );

  // advance tick count, saturating; past the limit the held command drops
  always_comb begin
    cnt_nxt = (cnt_r == CNT_TOP) ? cnt_r : cnt_r + 1'b1;
    to_nxt  = (cnt_nxt > TO_LIM);
    mix_lin = to_nxt ? '0 : held_lin_r;
    mix_ang = to_nxt ? '0 : held_ang_r;
  end

  vsdm_mix #(
    .LIN_GAIN_Q12 (LIN_GAIN_Q12),
    .ANG_GAIN_Q12 (ANG_GAIN_Q12)
  ) u_mix (
    .lin   (mix_lin),
    .ang   (mix_ang),
    .left  (left_nxt),
    .right (right_nxt)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_cfg_r <= '{vmax: VEL_RST_MAX, vmin: VEL_RST_MIN,
                     accel: STEP_RST, decel: STEP_RST};
      ang_cfg_r <= '{vmax: VEL_RST_MAX, vmin: VEL_RST_MIN,
                     accel: STEP_RST, decel: STEP_RST};
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_LIN_MAX:   lin_cfg_r.vmax  <= cfg_wdata;
        REG_LIN_MIN:   lin_cfg_r.vmin  <= cfg_wdata;
        REG_ANG_MAX:   ang_cfg_r.vmax  <= cfg_wdata;
        REG_ANG_MIN:   ang_cfg_r.vmin  <= cfg_wdata;
        REG_LIN_ACCEL: lin_cfg_r.accel <= cfg_wdata[STEP_W-1:0];
        REG_LIN_DECEL: lin_cfg_r.decel <= cfg_wdata[STEP_W-1:0];
        REG_ANG_ACCEL: ang_cfg_r.accel <= cfg_wdata[STEP_W-1:0];
        REG_ANG_DECEL: ang_cfg_r.decel <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: load on transfer, drop once processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
    end else if (in_acc) begin
      ivld_r <= 1'b1;
    end else if (adv) begin
      ivld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      iop_r  <= op_t'(in_opcode);
      ilin_r <= in_lin_cmd;
      iang_r <= in_ang_cmd;
    end
  end

  // Smoother state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_lin_r <= '0;
      last_ang_r <= '0;
      held_lin_r <= '0;
      held_ang_r <= '0;
      cnt_r      <= '0;
    end else if (adv) begin
      if (is_tick) begin
        cnt_r      <= cnt_nxt;
        held_lin_r <= mix_lin;
        held_ang_r <= mix_ang;
      end else begin
        last_lin_r <= slew_lin;
        last_ang_r <= slew_ang;
        held_lin_r <= slew_lin;
        held_ang_r <= slew_ang;
        cnt_r      <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && is_tick) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_tick) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      to_r    <= to_nxt;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_left_wheel_speed  = left_r;
  assign out_right_wheel_speed = right_r;
  assign out_timed_out         = to_r;

endmodule

// ===== sv/vsdm_slew.sv =====
`timescale 1ns / 1ps
module vsdm_slew
  import vsdm_pkg::*;
(
  input  axis_cfg_t cfg,
  input  vel_t      cur,
  input  vel_t      cmd,
  output vel_t      nxt
);

  vel_t                    clamped;
  logic signed [VEL_W:0]   cur_x;
  logic signed [VEL_W:0]   cmd_x;
  logic signed [VEL_W:0]   mag_cur;
  logic signed [VEL_W:0]   mag_cmd;
  logic signed [VEL_W:0]   dv;
  logic signed [VEL_W:0]   step_x;
  logic signed [VEL_W:0]   dv_lim;
  logic signed [VEL_W:0]   sum;
  logic                    opposite;

  always_comb begin
    // raise to min, then lower to max: max wins if they cross
    clamped = cmd;
    if (clamped < cfg.vmin) clamped = cfg.vmin;
    if (clamped > cfg.vmax) clamped = cfg.vmax;

    cur_x   = {cur[VEL_W-1], cur};
    cmd_x   = {clamped[VEL_W-1], clamped};
    mag_cur = cur_x[VEL_W] ? -cur_x : cur_x;
    mag_cmd = cmd_x[VEL_W] ? -cmd_x : cmd_x;
    opposite = (cur_x < 0 && cmd_x > 0) || (cur_x > 0 && cmd_x < 0);

    if (mag_cmd >= mag_cur && !opposite) begin
      step_x = $signed({2'b00, cfg.accel});
    end else begin
      step_x = $signed({2'b00, cfg.decel});
    end

    dv     = cmd_x - cur_x;
    dv_lim = dv;
    if (dv_lim < -step_x) dv_lim = -step_x;
    if (dv_lim > step_x)  dv_lim = step_x;

    // lands between cur and cmd, so it fits the velocity width
    sum = cur_x + dv_lim;
    nxt = sum[VEL_W-1:0];
  end

endmodule

// ===== sv/vsdm_mix.sv =====
`timescale 1ns / 1ps
module vsdm_mix
  import vsdm_pkg::*;
#(
  parameter int LIN_GAIN_Q12 = 24824,
  parameter int ANG_GAIN_Q12 = 7447
) (
  input  vel_t lin,
  input  vel_t ang,
  output whl_t left,
  output whl_t right
);

  localparam int PROD_W = VEL_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int Q_W    = SUM_W - FRAC_W;

  localparam logic signed [GAIN_W:0] LIN_G = (GAIN_W+1)'(LIN_GAIN_Q12);
  localparam logic signed [GAIN_W:0] ANG_G = (GAIN_W+1)'(ANG_GAIN_Q12);
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1 << (FRAC_W-1));
  localparam logic signed [Q_W-1:0] QMAX = Q_W'((1 << (WHL_W-1)) - 1);
  localparam logic signed [Q_W-1:0] QMIN = -Q_W'(1 << (WHL_W-1));

  logic signed [PROD_W-1:0] prod_l;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [SUM_W-1:0]  sum_l;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  rnd_l;
  logic signed [SUM_W-1:0]  rnd_r;
  logic signed [Q_W-1:0]    q_l;
  logic signed [Q_W-1:0]    q_r;

  function automatic whl_t sat(input logic signed [Q_W-1:0] q);
    whl_t res;
    if (q > QMAX) begin
      res = QMAX[WHL_W-1:0];
    end else if (q < QMIN) begin
      res = QMIN[WHL_W-1:0];
    end else begin
      res = q[WHL_W-1:0];
    end
    return res;
  endfunction

  always_comb begin
    prod_l = PROD_W'(lin) * PROD_W'(LIN_G);
    prod_a = PROD_W'(ang) * PROD_W'(ANG_G);
    sum_l  = SUM_W'(prod_l) + SUM_W'(prod_a);
    sum_r  = SUM_W'(prod_l) - SUM_W'(prod_a);
    // half rounds towards plus infinity, then floor
    rnd_l  = sum_l + HALF;
    rnd_r  = sum_r + HALF;
    q_l    = rnd_l[SUM_W-1:FRAC_W];
    q_r    = rnd_r[SUM_W-1:FRAC_W];
    left   = sat(q_l);
    right  = sat(q_r);
  end

endmodule
